// ----- src/wait_for_graph_deadlock_detector_assert.svh -----
// Assertion macros for the wait-for graph deadlock detector.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_ASSERT_SVH
`define WAIT_FOR_GRAPH_DEADLOCK_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WFG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfg assertion failed");

// Next-cycle implication, disabled during reset.
`define WFG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfg assertion failed");

`endif

// ----- src/wfg_pkg.sv -----
// Shared types and constants for the wait-for graph deadlock detector.
// No dependencies; imported by every module of the block.
package wfg_pkg;

    // Graph size and derived widths.
    localparam int MAX_VERTICES = 32;
    localparam int VIDX_W       = 5;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Request modes.
    localparam logic [1:0] MODE_ADD_VERTEX = 2'd0;
    localparam logic [1:0] MODE_ADD_EDGE   = 2'd1;
    localparam logic [1:0] MODE_DEL_EDGE   = 2'd2;
    localparam logic [1:0] MODE_CHECK      = 2'd3;

    // Response status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_SELF    = 3'd3;
    localparam logic [2:0] ST_EXISTS  = 3'd4;
    localparam logic [2:0] ST_ABSENT  = 3'd5;

    // Request and response payloads.
    typedef struct packed {
        logic [1:0]        mode;
        logic [VIDX_W-1:0] from_vertex;
        logic [VIDX_W-1:0] to_vertex;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [VIDX_W-1:0] new_index;
        logic              deadlock;
    } rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_SCAN,
        S_DONE
    } state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_EXEC,
        OP_START,
        OP_ROOT_SKIP,
        OP_ROOT_ENTER,
        OP_NEXT,
        OP_PUSH,
        OP_POP,
        OP_FOUND,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    // Datapath conditions seen by the controller.
    typedef struct packed {
        logic rsp_free;
        logic root_end;
        logic root_seen;
        logic scan_end;
        logic edge_hit;
        logic hit_visited;
        logic hit_on_stack;
        logic stack_empty;
    } stat_t;

endpackage

// ----- src/wfg_dp.sv -----
// Datapath of the deadlock detector: edge matrix, vertex count, search marks,
// search stack and response register. Depends on wfg_pkg.
module wfg_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  wfg_pkg::req_t req,
    input  wfg_pkg::cmd_t cmd,
    input  logic          rsp_stall,
    output logic          rsp_valid,
    output wfg_pkg::rsp_t rsp,
    output wfg_pkg::stat_t stat
);
    import wfg_pkg::*;

    logic [MAX_VERTICES-1:0] edge_rows_reg [MAX_VERTICES];
    logic [CNT_W-1:0]        count_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] on_stack_reg;
    logic [CNT_W-1:0]        root_reg;
    logic [VIDX_W-1:0]       top_v_reg;
    logic [CNT_W-1:0]        top_n_reg;
    logic [VIDX_W-1:0]       sp_reg;
    logic                    found_reg;
    logic                    rsp_valid_reg;
    rsp_t                    rsp_reg;

    // Parent frames of the search; the current frame lives in top_v/top_n.
    logic [VIDX_W-1:0]       stk_v [MAX_VERTICES];
    logic [CNT_W-1:0]        stk_n [MAX_VERTICES];

    logic                    rd_bit;
    logic                    ed_bit;
    logic [VIDX_W-1:0]       sp_dec;
    logic [VIDX_W-1:0]       root_idx;
    logic [VIDX_W-1:0]       n_idx;
    logic                    from_bad;
    logic                    to_bad;
    logic [2:0]              ex_status;
    logic [VIDX_W-1:0]       ex_index;
    logic                    ex_set;
    logic                    ex_clr;
    logic                    ex_inc;
    logic                    load_rsp;
    rsp_t                    rsp_next;

    assign root_idx = root_reg[VIDX_W-1:0];
    assign n_idx    = top_n_reg[VIDX_W-1:0];
    assign sp_dec   = sp_reg - VIDX_W'(1);

    // Edge bit under the search cursor, and edge bit named by an edit request.
    assign rd_bit = edge_rows_reg[top_v_reg][n_idx];
    assign ed_bit = edge_rows_reg[req.from_vertex][req.to_vertex];

    // Status toward the controller.
    assign stat.rsp_free     = !rsp_valid_reg || !rsp_stall;
    assign stat.root_end     = root_reg >= count_reg;
    assign stat.root_seen    = visited_reg[root_idx];
    assign stat.scan_end     = top_n_reg >= count_reg;
    assign stat.edge_hit     = rd_bit;
    assign stat.hit_visited  = visited_reg[n_idx];
    assign stat.hit_on_stack = on_stack_reg[n_idx];
    assign stat.stack_empty  = (sp_reg == '0);

    // Result of an add-vertex or edge edit request.
    assign from_bad = {1'b0, req.from_vertex} >= count_reg;
    assign to_bad   = {1'b0, req.to_vertex} >= count_reg;

    always_comb
    begin
        ex_status = ST_OK;
        ex_index  = '0;
        ex_set    = 1'b0;
        ex_clr    = 1'b0;
        ex_inc    = 1'b0;
        case (req.mode)
            MODE_ADD_VERTEX:
            begin
                if (count_reg == CNT_W'(MAX_VERTICES))
                begin
                    ex_status = ST_FULL;
                end
                else
                begin
                    ex_index = count_reg[VIDX_W-1:0];
                    ex_inc   = 1'b1;
                end
            end
            MODE_ADD_EDGE, MODE_DEL_EDGE:
            begin
                if (req.from_vertex == req.to_vertex)
                begin
                    ex_status = ST_SELF;
                end
                else if (from_bad || to_bad)
                begin
                    ex_status = ST_UNKNOWN;
                end
                else if (req.mode == MODE_ADD_EDGE)
                begin
                    if (ed_bit)
                        ex_status = ST_EXISTS;
                    else
                        ex_set = 1'b1;
                end
                else
                begin
                    if (ed_bit)
                        ex_clr = 1'b1;
                    else
                        ex_status = ST_ABSENT;
                end
            end
            default:
            begin
                ex_status = ST_OK;
            end
        endcase
    end

    // Response register: loaded by an edit or by the end of a check.
    always_comb
    begin
        load_rsp = 1'b0;
        rsp_next = rsp_reg;
        if (cmd.op == OP_EXEC)
        begin
            load_rsp           = 1'b1;
            rsp_next.status    = ex_status;
            rsp_next.new_index = ex_index;
            rsp_next.deadlock  = 1'b0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            load_rsp           = 1'b1;
            rsp_next.status    = ST_OK;
            rsp_next.new_index = '0;
            rsp_next.deadlock  = found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load_rsp)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Edge matrix and vertex count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
                edge_rows_reg[i] <= '0;
            count_reg <= '0;
        end
        else if (cmd.op == OP_EXEC)
        begin
            if (ex_set)
                edge_rows_reg[req.from_vertex][req.to_vertex] <= 1'b1;
            if (ex_clr)
                edge_rows_reg[req.from_vertex][req.to_vertex] <= 1'b0;
            if (ex_inc)
                count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Search marks, root counter, current frame and stack pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            on_stack_reg <= '0;
            root_reg     <= '0;
            top_v_reg    <= '0;
            top_n_reg    <= '0;
            sp_reg       <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_START:
                begin
                    visited_reg  <= '0;
                    on_stack_reg <= '0;
                    root_reg     <= '0;
                    sp_reg       <= '0;
                    found_reg    <= 1'b0;
                end
                OP_ROOT_SKIP:
                begin
                    root_reg <= root_reg + CNT_W'(1);
                end
                OP_ROOT_ENTER:
                begin
                    visited_reg[root_idx]  <= 1'b1;
                    on_stack_reg[root_idx] <= 1'b1;
                    top_v_reg              <= root_idx;
                    top_n_reg              <= '0;
                    sp_reg                 <= '0;
                end
                OP_NEXT:
                begin
                    top_n_reg <= top_n_reg + CNT_W'(1);
                end
                OP_PUSH:
                begin
                    visited_reg[n_idx]  <= 1'b1;
                    on_stack_reg[n_idx] <= 1'b1;
                    top_v_reg           <= n_idx;
                    top_n_reg           <= '0;
                    sp_reg              <= sp_reg + VIDX_W'(1);
                end
                OP_POP:
                begin
                    on_stack_reg[top_v_reg] <= 1'b0;
                    if (sp_reg == '0)
                    begin
                        root_reg <= root_reg + CNT_W'(1);
                    end
                    else
                    begin
                        top_v_reg <= stk_v[sp_dec];
                        top_n_reg <= stk_n[sp_dec];
                        sp_reg    <= sp_dec;
                    end
                end
                OP_FOUND:
                begin
                    found_reg <= 1'b1;
                end
                default:
                begin
                    found_reg <= found_reg;
                end
            endcase
        end
    end

    // A push saves the parent frame, resuming after the edge just taken.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUSH)
        begin
            stk_v[sp_reg] <= top_v_reg;
            stk_n[sp_reg] <= top_n_reg + CNT_W'(1);
        end
    end

endmodule

// ----- src/wfg_ctrl.sv -----
// Controller of the deadlock detector: request handshake and the state
// machine that steps the depth-first search. Depends on wfg_pkg.
module wfg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_mode,
    output logic           req_stall,
    input  wfg_pkg::stat_t stat,
    output wfg_pkg::cmd_t  cmd
);
    import wfg_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // A request is taken only when idle and the response register can be loaded.
    assign req_stall = !((state_reg == S_IDLE) && stat.rsp_free);

    // Next state and datapath operation.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    if (req_mode == MODE_CHECK)
                    begin
                        cmd.op     = OP_START;
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        cmd.op = OP_EXEC;
                    end
                end
            end
            S_ROOT:
            begin
                if (stat.root_end)
                begin
                    state_next = S_DONE;
                end
                else if (stat.root_seen)
                begin
                    cmd.op = OP_ROOT_SKIP;
                end
                else
                begin
                    cmd.op     = OP_ROOT_ENTER;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd.op = OP_POP;
                    if (stat.stack_empty)
                        state_next = S_ROOT;
                end
                else if (stat.edge_hit && !stat.hit_visited)
                begin
                    cmd.op = OP_PUSH;
                end
                else if (stat.edge_hit && stat.hit_on_stack)
                begin
                    cmd.op     = OP_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_NEXT;
                end
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/wait_for_graph_deadlock_detector.sv -----
// Top level of the wait-for graph deadlock detector.
// Joins wfg_ctrl and wfg_dp; depends on wfg_pkg and the assertion header.
//
// Add-vertex, add-edge and remove-edge requests load the response register
// directly, and the next request can be taken in the following cycle unless
// that response is stalled. A cycle check walks the edge matrix one bit per
// clock in the search sequencer: each root index is skipped or entered in
// turn, each edge position of an entered vertex is scanned (a push takes the
// place of the position it leaves), and each entered vertex is popped when
// its scan ends; the search then leaves the root loop and loads the response,
// stopping early when a cycle is found. No request is taken during a check.
// Each request yields exactly one response, held in an output register; a
// new request is taken in the cycle in which a waiting response is accepted,
// but not while that response stays stalled.
module wait_for_graph_deadlock_detector (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  wfg_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output wfg_pkg::rsp_t rsp
);
    import wfg_pkg::*;

    `include "wait_for_graph_deadlock_detector_assert.svh"

    cmd_t  wfg_cmd;
    stat_t wfg_stat;
    logic  rsp_load;

    // Control.
    wfg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .req_stall (req_stall),
        .stat      (wfg_stat),
        .cmd       (wfg_cmd)
    );

    // Datapath.
    wfg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (wfg_cmd),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .stat      (wfg_stat)
    );

    // Operations that load the response register.
    assign rsp_load = (wfg_cmd.op == OP_EXEC) || (wfg_cmd.op == OP_FINISH);

    // A check request keeps the request side stalled in the next cycle.
    `WFG_ASSERT_NEXT(a_check_busy, req_valid && !req_stall && (req.mode == MODE_CHECK), req_stall)

    // An edit request has its response valid in the next cycle.
    `WFG_ASSERT_NEXT(a_edit_rsp, req_valid && !req_stall && (req.mode != MODE_CHECK), rsp_valid)

    // After a push the search stack holds at least one parent frame.
    `WFG_ASSERT_NEXT(a_push_depth, wfg_cmd.op == OP_PUSH, !wfg_stat.stack_empty)

    // The response register is loaded only when it is free.
    `WFG_ASSERT_SAME(a_load_free, rsp_load, wfg_stat.rsp_free)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the wait-for graph deadlock detector.
// Holds its own graph model to predict every response; depends on wfg_pkg
// and the top level wait_for_graph_deadlock_detector.
module tb;
    import wfg_pkg::*;

    // One queued request together with the idling phase it belongs to.
    typedef struct {
        req_t        r;
        int unsigned ph;
    } pend_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Idling per phase: none, sender idle, receiver stalling, both.
    int unsigned send_idle_pct [4] = '{0, 45, 0, 24};
    int unsigned rsp_stall_pct [4] = '{0, 0, 45, 24};
    int unsigned cur_phase = 0;
    logic        rsp_hold  = 1'b0;

    // Request stream and expected responses.
    pend_t       pending_req [$];
    pend_t       head;
    rsp_t        expected_rsp [$];
    rsp_t        want;
    int unsigned req_total    = 0;
    int unsigned req_accepted = 0;
    int unsigned rsp_seen     = 0;
    int unsigned err_count    = 0;

    // Graph as the block should hold it.
    logic [MAX_VERTICES-1:0] graph_rows [MAX_VERTICES];
    logic [6:0]              graph_vcount = '0;

    // Stimulus-side view: vertices added and edges worth removing later.
    int unsigned gen_vcnt = 0;
    logic [9:0]  fwd_pairs [$];
    logic [9:0]  back_pairs [$];

    wait_for_graph_deadlock_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A cycle exists when peeling off vertices with no live successor
    // leaves something behind.
    function automatic logic graph_has_cycle();
        logic [MAX_VERTICES-1:0] live;
        logic                    changed;
        live = MAX_VERTICES'((64'd1 << graph_vcount) - 64'd1);
        do
        begin
            changed = 1'b0;
            for (int v = 0; v < MAX_VERTICES; v++)
            begin
                if (live[v] && (graph_rows[v] & live) == '0)
                begin
                    live[v] = 1'b0;
                    changed = 1'b1;
                end
            end
        end
        while (changed);
        return live != '0;
    endfunction

    // Applies one request to the graph and returns the response it gives.
    function automatic rsp_t graph_apply(req_t r);
        rsp_t o;
        o = '0;
        case (r.mode)
            MODE_ADD_VERTEX:
            begin
                if (graph_vcount >= MAX_VERTICES)
                    o.status = ST_FULL;
                else
                begin
                    o.new_index  = graph_vcount[VIDX_W-1:0];
                    graph_vcount = graph_vcount + 7'd1;
                end
            end
            MODE_ADD_EDGE, MODE_DEL_EDGE:
            begin
                if (r.from_vertex == r.to_vertex)
                    o.status = ST_SELF;
                else if (r.from_vertex >= graph_vcount || r.to_vertex >= graph_vcount)
                    o.status = ST_UNKNOWN;
                else if (r.mode == MODE_ADD_EDGE)
                begin
                    if (graph_rows[r.from_vertex][r.to_vertex])
                        o.status = ST_EXISTS;
                    else
                        graph_rows[r.from_vertex][r.to_vertex] = 1'b1;
                end
                else
                begin
                    if (graph_rows[r.from_vertex][r.to_vertex])
                        graph_rows[r.from_vertex][r.to_vertex] = 1'b0;
                    else
                        o.status = ST_ABSENT;
                end
            end
            default:
                o.deadlock = graph_has_cycle();
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        $display("mismatch on response %0d: %s got %0d, expected %0d",
                 rsp_seen, what, got, exp_val);
        err_count++;
    endtask

    task automatic push_req(input logic [1:0] mode, input int unsigned f,
                            input int unsigned t, input int unsigned ph);
        pend_t p;
        p.r.mode        = mode;
        p.r.from_vertex = f[VIDX_W-1:0];
        p.r.to_vertex   = t[VIDX_W-1:0];
        p.ph            = ph;
        pending_req.push_back(p);
    endtask

    // Random requests: the graph grows slowly, edges mostly point forward
    // so cycles come and go, and removals mostly target edges once added.
    task automatic fill_random(input int unsigned count);
        int unsigned ph;
        int unsigned sel;
        int unsigned add_pct;
        int unsigned a;
        int unsigned b;
        int unsigned idx;
        logic [9:0]  pr;
        for (int unsigned k = 0; k < count; k++)
        begin
            ph  = (k / 70) % 4;
            sel = $urandom_range(99);
            add_pct = (gen_vcnt < 4) ? 30 : (gen_vcnt < MAX_VERTICES) ? 10 : 3;
            if (sel < add_pct)
            begin
                push_req(MODE_ADD_VERTEX, $urandom_range(31), $urandom_range(31), ph);
                if (gen_vcnt < MAX_VERTICES)
                    gen_vcnt++;
            end
            else if (sel < 88 && gen_vcnt >= 2)
            begin
                if (sel < 50)
                begin
                    // New edge between two known vertices.
                    a = $urandom_range(gen_vcnt - 1);
                    b = $urandom_range(gen_vcnt - 2);
                    if (b >= a)
                        b++;
                    if ($urandom_range(99) < 85)
                    begin
                        pr = (a < b) ? {a[4:0], b[4:0]} : {b[4:0], a[4:0]};
                        fwd_pairs.push_back(pr);
                    end
                    else
                    begin
                        pr = (a > b) ? {a[4:0], b[4:0]} : {b[4:0], a[4:0]};
                        back_pairs.push_back(pr);
                    end
                    push_req(MODE_ADD_EDGE, 32'(pr[9:5]), 32'(pr[4:0]), ph);
                end
                else if (sel < 76)
                begin
                    // Removal, mostly of back edges so deadlocks clear again.
                    if (back_pairs.size() != 0 &&
                        ($urandom_range(99) < 70 || fwd_pairs.size() == 0))
                    begin
                        idx = $urandom_range(back_pairs.size() - 1);
                        pr  = back_pairs[idx];
                        back_pairs.delete(idx);
                    end
                    else if (fwd_pairs.size() != 0)
                    begin
                        idx = $urandom_range(fwd_pairs.size() - 1);
                        pr  = fwd_pairs[idx];
                        fwd_pairs.delete(idx);
                    end
                    else
                    begin
                        a  = $urandom_range(31);
                        b  = $urandom_range(31);
                        pr = {a[4:0], b[4:0]};
                    end
                    push_req(MODE_DEL_EDGE, 32'(pr[9:5]), 32'(pr[4:0]), ph);
                end
                else
                    push_req(MODE_CHECK, $urandom_range(31), $urandom_range(31), ph);
            end
            else
            begin
                // Noise: self edges, out-of-range vertices, plain random pairs.
                a = $urandom_range(31);
                if ($urandom_range(1) == 0)
                    b = a;
                else if (gen_vcnt < MAX_VERTICES)
                    b = $urandom_range(31, gen_vcnt);
                else
                    b = $urandom_range(31);
                if ($urandom_range(1) == 0)
                    push_req(MODE_ADD_EDGE, a, b, ph);
                else
                    push_req(MODE_DEL_EDGE, b, a, ph);
            end
        end
    endtask

    // Request driver: predicts each accepted request and presents the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(graph_apply(req));
                req_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_req.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct[pending_req[0].ph])
                begin
                    head = pending_req.pop_front();
                    req       <= head.r;
                    req_valid <= 1'b1;
                    cur_phase <= head.ph;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor: compares each accepted response with the oldest
    // expectation and decides the stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unrequested response, status", 32'(rsp.status), 32'd0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.new_index !== want.new_index)
                        report_mismatch("new_index", 32'(rsp.new_index),
                                        32'(want.new_index));
                    if (rsp.deadlock !== want.deadlock)
                        report_mismatch("deadlock", 32'(rsp.deadlock), 32'(want.deadlock));
                end
                rsp_seen++;
            end
            rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct[cur_phase]);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial
    begin : rsp_hold_off
        int unsigned n;
        while (req_accepted < 40)
            @(posedge clk);
        rsp_hold <= 1'b1;
        for (n = 0; n < 400; n++)
            @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #(64'd12 * 64'd3_000_000);
        $display("** wait_for_graph_deadlock_detector: FAILED **");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        for (int v = 0; v < MAX_VERTICES; v++)
            graph_rows[v] = '0;

        // Directed requests on a small graph.
        push_req(MODE_CHECK, 31, 31, 0);
        push_req(MODE_ADD_EDGE, 0, 1, 0);
        push_req(MODE_ADD_EDGE, 4, 4, 0);
        push_req(MODE_DEL_EDGE, 1, 0, 0);
        push_req(MODE_DEL_EDGE, 31, 31, 0);
        for (int i = 0; i < 3; i++)
            push_req(MODE_ADD_VERTEX, $urandom_range(31), $urandom_range(31), 0);
        push_req(MODE_ADD_EDGE, 0, 1, 0);
        push_req(MODE_ADD_EDGE, 0, 1, 0);
        push_req(MODE_ADD_EDGE, 1, 2, 0);
        push_req(MODE_CHECK, 0, 0, 0);
        push_req(MODE_ADD_EDGE, 2, 0, 0);
        push_req(MODE_CHECK, 21, 10, 0);
        push_req(MODE_DEL_EDGE, 2, 0, 0);
        push_req(MODE_DEL_EDGE, 2, 0, 0);
        push_req(MODE_ADD_EDGE, 0, 3, 0);
        push_req(MODE_DEL_EDGE, 3, 1, 0);
        push_req(MODE_CHECK, 10, 21, 0);
        gen_vcnt = 3;
        fwd_pairs.push_back({5'd0, 5'd1});
        fwd_pairs.push_back({5'd1, 5'd2});

        fill_random(540);

        // Fill the table and go one past it, then a last check.
        while (gen_vcnt <= MAX_VERTICES)
        begin
            push_req(MODE_ADD_VERTEX, $urandom_range(31), $urandom_range(31), 0);
            gen_vcnt++;
        end
        push_req(MODE_CHECK, 0, 31, 0);
        req_total = pending_req.size();

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (req_accepted < req_total || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0)
            $display("** wait_for_graph_deadlock_detector: PASSED **");
        else
            $display("** wait_for_graph_deadlock_detector: FAILED **");
        $finish;
    end

endmodule
